[rtl/rld_pkg.sv]
`default_nettype none

package rld_pkg;

   localparam int MAX_WIDTH = 8192;

   localparam int COL_W  = 14;
   localparam int LINE_W = 16;
   localparam int CNT_W  = 9;
   localparam int BPP_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PIXEL = 2'd2;

   localparam logic [7:0] CODE_FILL = 8'h80;

   typedef enum logic [1:0] {
      RK_SEGMENT = 2'd0,
      RK_COMMIT  = 2'd1,
      RK_STATUS  = 2'd2
   } result_kind_type;

   typedef struct packed {
      result_kind_type    kind;
      logic [12:0]        start_pos;
      logic [COL_W-1:0]   run_length;
      logic [31:0]        pixel_value;
      logic [LINE_W-1:0]  first_line;
      logic [CNT_W-1:0]   line_count;
      logic               page_done;
      logic               truncated;
      logic               last;
   } res_type;

endpackage

`default_nettype wire

[rtl/raster_line_rle_decoder.sv]
`default_nettype none

// Run-length raster line decoder. Takes one compressed byte per cycle on req_
// while req_stall is low and turns it into pixel segment descriptors, line
// commits and an end-of-stream status on rsp_. Every byte is decoded in the
// cycle it is accepted, unless a csr_ write hits a register; results are
// written into a four-entry result queue and read out onto rsp_, one result
// per clock while rsp_stall is low. A byte that finishes a line gives two
// results, and req_stall is raised while the queue has fewer than two free
// entries, so the output port is what limits a stream of line ends. A csr_
// write to a used register index also restarts decoding at the top of a page.
module raster_line_rle_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [rld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rld_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_kind,
   input  wire logic [7:0]                     req_data_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_result_kind,
   output logic [12:0]                         rsp_start_pos,
   output logic [rld_pkg::COL_W-1:0]           rsp_run_length,
   output logic [31:0]                         rsp_pixel_value,
   output logic [rld_pkg::LINE_W-1:0]          rsp_first_line,
   output logic [rld_pkg::CNT_W-1:0]           rsp_line_count,
   output logic                                rsp_page_done,
   output logic                                rsp_truncated,
   output logic                                rsp_last
);

   typedef enum logic [1:0] {PH_REPEAT, PH_CODE, PH_RUN, PH_LIT} phase_type;

   localparam int COL_W  = rld_pkg::COL_W;
   localparam int LINE_W = rld_pkg::LINE_W;
   localparam int CNT_W  = rld_pkg::CNT_W;
   localparam int BPP_W  = rld_pkg::BPP_W;
   localparam int QPTR_W = rld_pkg::QPTR_W;
   localparam int QCNT_W = rld_pkg::QCNT_W;

   // configuration
   logic [COL_W-1:0]  width_ff,  width_in;
   logic [LINE_W-1:0] height_ff, height_in;
   logic [BPP_W-1:0]  bpp_ff,    bpp_in;

   // decoder state
   phase_type         phase_ff, phase_in;
   logic [LINE_W-1:0] line_index_ff, line_index_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [CNT_W-1:0]  repeat_ff, repeat_in;
   logic [7:0]        literal_ff, literal_in;
   logic [7:0]        run_ff, run_in;
   logic [1:0]        byte_cnt_ff, byte_cnt_in;
   logic [31:0]       accum_ff, accum_in;
   logic              started_ff, started_in;

   // result queue
   rld_pkg::res_type  queue_ff [rld_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic              accept;
   logic              pop;
   logic              push0, push1;
   rld_pkg::res_type  ent0, ent1;
   rld_pkg::res_type  head;

   logic [COL_W-1:0]  w_eff;
   logic [LINE_W-1:0] h_eff;
   logic [BPP_W-1:0]  bpp_eff;
   logic [31:0]       ones;

   logic              do_seg;
   logic [COL_W-1:0]  seg_len;
   logic [31:0]       seg_val;
   logic [COL_W-1:0]  room;
   logic [COL_W-1:0]  len_clip;
   logic [COL_W-1:0]  col_after;
   logic              full;
   logic [LINE_W-1:0] lines_left;
   logic [CNT_W-1:0]  cnt_clip;
   logic [LINE_W:0]   li_sum;
   logic              done;
   logic [31:0]       acc_next;
   logic [BPP_W-1:0]  byte_next;
   logic [7:0]        lit_dec;
   logic              cfg_hit;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > QCNT_W'(rld_pkg::QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign head      = queue_ff[rd_ptr_ff];

   assign rsp_result_kind = head.kind;
   assign rsp_start_pos   = head.start_pos;
   assign rsp_run_length  = head.run_length;
   assign rsp_pixel_value = head.pixel_value;
   assign rsp_first_line  = head.first_line;
   assign rsp_line_count  = head.line_count;
   assign rsp_page_done   = head.page_done;
   assign rsp_truncated   = head.truncated;
   assign rsp_last        = head.last;

   // effective configuration
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = COL_W'(1);
      end else if (width_ff > COL_W'(rld_pkg::MAX_WIDTH)) begin
         w_eff = COL_W'(rld_pkg::MAX_WIDTH);
      end
      h_eff = (height_ff == '0) ? LINE_W'(1) : height_ff;
      bpp_eff = bpp_ff;
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(4)) begin
         bpp_eff = BPP_W'(4);
      end
      case (bpp_eff)
         BPP_W'(1): ones = 32'h0000_00FF;
         BPP_W'(2): ones = 32'h0000_FFFF;
         BPP_W'(3): ones = 32'h00FF_FFFF;
         default:   ones = 32'hFFFF_FFFF;
      endcase
   end

   // byte decode
   always_comb begin
      phase_in      = phase_ff;
      line_index_in = line_index_ff;
      column_in     = column_ff;
      repeat_in     = repeat_ff;
      literal_in    = literal_ff;
      run_in        = run_ff;
      byte_cnt_in   = byte_cnt_ff;
      accum_in      = accum_ff;
      started_in    = started_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      bpp_in        = bpp_ff;
      push0         = 1'b0;
      push1         = 1'b0;
      ent0          = '0;
      ent1          = '0;
      do_seg        = 1'b0;
      seg_len       = '0;
      seg_val       = '0;

      acc_next  = {accum_ff[23:0], req_data_byte};
      byte_next = BPP_W'(byte_cnt_ff) + BPP_W'(1);
      lit_dec   = literal_ff - 8'd1;

      cfg_hit = 1'b0;
      if (csr_write) begin
         case (csr_index)
            rld_pkg::CSR_LINE_WIDTH: begin
               width_in = csr_wdata[COL_W-1:0];
               cfg_hit  = 1'b1;
            end
            rld_pkg::CSR_PAGE_HEIGHT: begin
               height_in = csr_wdata[LINE_W-1:0];
               cfg_hit   = 1'b1;
            end
            rld_pkg::CSR_BYTES_PIXEL: begin
               bpp_in  = csr_wdata[BPP_W-1:0];
               cfg_hit = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end

      if (accept && !cfg_hit) begin
         if (req_kind) begin
            push0          = 1'b1;
            ent0.kind      = rld_pkg::RK_STATUS;
            ent0.truncated = started_ff;
            ent0.last      = 1'b1;
         end else begin
            case (phase_ff)
               PH_REPEAT: begin
                  repeat_in  = CNT_W'(req_data_byte) + CNT_W'(1);
                  column_in  = '0;
                  started_in = 1'b1;
                  phase_in   = PH_CODE;
               end
               PH_CODE: begin
                  if (req_data_byte == rld_pkg::CODE_FILL) begin
                     do_seg  = 1'b1;
                     seg_len = w_eff;
                     seg_val = ones;
                  end else begin
                     byte_cnt_in = '0;
                     accum_in    = '0;
                     if (!req_data_byte[7]) begin
                        run_in   = req_data_byte + 8'd1;
                        phase_in = PH_RUN;
                     end else begin
                        literal_in = 8'(9'd257 - {1'b0, req_data_byte});
                        phase_in   = PH_LIT;
                     end
                  end
               end
               default: begin
                  if (byte_next < bpp_eff) begin
                     accum_in    = acc_next;
                     byte_cnt_in = byte_next[1:0];
                  end else begin
                     accum_in    = '0;
                     byte_cnt_in = '0;
                     do_seg      = 1'b1;
                     seg_val     = acc_next;
                     if (phase_ff == PH_RUN) begin
                        phase_in = PH_CODE;
                        seg_len  = COL_W'(run_ff);
                     end else begin
                        literal_in = lit_dec;
                        phase_in   = (lit_dec == '0) ? PH_CODE : PH_LIT;
                        seg_len    = COL_W'(1);
                     end
                  end
               end
            endcase
         end
      end

      // segment clipping and line commit
      room      = (column_ff < w_eff) ? (w_eff - column_ff) : '0;
      len_clip  = (seg_len > room) ? room : seg_len;
      col_after = column_ff + len_clip;
      full      = col_after >= w_eff;
      lines_left = (line_index_ff < h_eff) ? (h_eff - line_index_ff) : '0;
      cnt_clip  = (lines_left > LINE_W'(repeat_ff)) ? repeat_ff : lines_left[CNT_W-1:0];
      li_sum    = {1'b0, line_index_ff} + (LINE_W+1)'(cnt_clip);
      done      = li_sum >= {1'b0, h_eff};

      if (do_seg) begin
         column_in = col_after;
         if (len_clip != '0) begin
            push0            = 1'b1;
            ent0.kind        = rld_pkg::RK_SEGMENT;
            ent0.start_pos   = column_ff[12:0];
            ent0.run_length  = len_clip;
            ent0.pixel_value = seg_val;
            ent0.last        = !full;
         end
         if (full) begin
            phase_in  = PH_REPEAT;
            column_in = '0;
            if (done) begin
               line_index_in = '0;
               started_in    = 1'b0;
            end else begin
               line_index_in = li_sum[LINE_W-1:0];
            end
            if (len_clip != '0) begin
               push1           = 1'b1;
               ent1.kind       = rld_pkg::RK_COMMIT;
               ent1.first_line = line_index_ff;
               ent1.line_count = cnt_clip;
               ent1.page_done  = done;
               ent1.last       = 1'b1;
            end else begin
               push0           = 1'b1;
               ent0.kind       = rld_pkg::RK_COMMIT;
               ent0.first_line = line_index_ff;
               ent0.line_count = cnt_clip;
               ent0.page_done  = done;
               ent0.last       = 1'b1;
            end
         end
      end

      // end of stream and configuration both restart the page
      if (cfg_hit || (accept && req_kind)) begin
         phase_in      = PH_REPEAT;
         line_index_in = '0;
         column_in     = '0;
         repeat_in     = CNT_W'(1);
         literal_in    = '0;
         run_in        = '0;
         byte_cnt_in   = '0;
         accum_in      = '0;
         started_in    = 1'b0;
      end

      wr_ptr_in = wr_ptr_ff + QPTR_W'(push0) + QPTR_W'(push1);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= COL_W'(1);
         height_ff     <= LINE_W'(1);
         bpp_ff        <= BPP_W'(3);
         phase_ff      <= PH_REPEAT;
         line_index_ff <= '0;
         column_ff     <= '0;
         repeat_ff     <= CNT_W'(1);
         literal_ff    <= '0;
         run_ff        <= '0;
         byte_cnt_ff   <= '0;
         accum_ff      <= '0;
         started_ff    <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         bpp_ff        <= bpp_in;
         phase_ff      <= phase_in;
         line_index_ff <= line_index_in;
         column_ff     <= column_in;
         repeat_ff     <= repeat_in;
         literal_ff    <= literal_in;
         run_ff        <= run_in;
         byte_cnt_ff   <= byte_cnt_in;
         accum_ff      <= accum_in;
         started_ff    <= started_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
      if (push0) begin
         queue_ff[wr_ptr_ff] <= ent0;
      end
      if (push1) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= ent1;
      end
   end

endmodule

`default_nettype wire

[rtl/rld_checker.sv]
`default_nettype none

module rld_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [1:0]                     rsp_result_kind,
   input wire logic [rld_pkg::COL_W-1:0]      rsp_run_length,
   input wire logic [31:0]                    rsp_pixel_value,
   input wire logic [rld_pkg::CNT_W-1:0]      rsp_line_count,
   input wire logic                           rsp_last
);

   // a segment that fills the line is always followed at once by its commit
   a_seg_then_commit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         (rsp_valid && rsp_result_kind == rld_pkg::RK_COMMIT))
      else $error("line-ending segment not followed by its commit");

   a_commit_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == rld_pkg::RK_COMMIT) |->
         (rsp_last && rsp_line_count != '0 && rsp_run_length == '0))
      else $error("malformed line commit");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == rld_pkg::RK_STATUS) |->
         (rsp_last && rsp_run_length == '0 && rsp_line_count == '0))
      else $error("malformed stream end status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_result_kind) && $stable(rsp_pixel_value)))
      else $error("stalled result changed");

endmodule

bind raster_line_rle_decoder rld_checker u_rld_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_run_length  (rsp_run_length),
   .rsp_pixel_value (rsp_pixel_value),
   .rsp_line_count  (rsp_line_count),
   .rsp_last        (rsp_last)
);

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rld_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 620;
   localparam int PHASE_ITEMS  = 90;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      AWAIT_REPEAT,
      AWAIT_CODE,
      RUN_PIXEL,
      COPY_PIXEL
   } decode_phase_type;

   typedef struct packed {
      logic       end_of_stream;
      logic [7:0] data;
   } stream_item_type;

   class raster_decode_scoreboard;
      logic [COL_W-1:0]  width_reg;
      logic [LINE_W-1:0] height_reg;
      logic [BPP_W-1:0]  bpp_reg;

      decode_phase_type  phase;
      logic [LINE_W-1:0] line_index;
      logic [COL_W-1:0]  column;
      logic [CNT_W-1:0]  repeat_lines;
      logic [7:0]        literal_left;
      logic [7:0]        run_pixels;
      logic [2:0]        byte_count;
      logic [31:0]       pixel_accum;
      logic              page_started;

      res_type           pending_results[$];
      int                errors;

      function new();
         width_reg = 1;
         height_reg = 1;
         bpp_reg = 3;
         errors = 0;
         restart_page();
      endfunction

      function void restart_page();
         phase = AWAIT_REPEAT;
         line_index = '0;
         column = '0;
         repeat_lines = 1;
         literal_left = '0;
         run_pixels = '0;
         byte_count = '0;
         pixel_accum = '0;
         page_started = 1'b0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function int unsigned eff_bpp();
         if (bpp_reg == 0) return 1;
         if (bpp_reg > 4) return 4;
         return bpp_reg;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_LINE_WIDTH:  width_reg = value[COL_W-1:0];
            CSR_PAGE_HEIGHT: height_reg = value[LINE_W-1:0];
            CSR_BYTES_PIXEL: bpp_reg = value[BPP_W-1:0];
            default: return;
         endcase
         restart_page();
      endfunction

      // clip the run at the line end, then commit the line once it is full
      function void place_run(input int unsigned len, input logic [31:0] value);
         int unsigned w, room, h, cnt;
         res_type seg, commit;
         w = eff_width();
         room = (column < w) ? w - column : 0;
         if (len > room) len = room;
         seg = '0;
         if (len > 0) begin
            seg.kind = RK_SEGMENT;
            seg.start_pos = column[12:0];
            seg.run_length = len[COL_W-1:0];
            seg.pixel_value = value;
            column = column + len[COL_W-1:0];
         end
         if (column < w) begin
            seg.last = 1'b1;
            pending_results.push_back(seg);
            return;
         end
         if (len > 0) pending_results.push_back(seg);
         h = eff_height();
         cnt = (line_index < h) ? h - line_index : 0;
         if (cnt > repeat_lines) cnt = repeat_lines;
         commit = '0;
         commit.kind = RK_COMMIT;
         commit.first_line = line_index;
         commit.line_count = cnt[CNT_W-1:0];
         line_index = line_index + cnt[LINE_W-1:0];
         commit.page_done = (line_index >= h);
         commit.last = 1'b1;
         pending_results.push_back(commit);
         phase = AWAIT_REPEAT;
         column = '0;
         if (commit.page_done) begin
            line_index = '0;
            page_started = 1'b0;
         end
      endfunction

      function void note_item(input logic end_of_stream, input logic [7:0] b);
         int unsigned bpp;
         res_type status;
         bpp = eff_bpp();
         if (end_of_stream) begin
            status = '0;
            status.kind = RK_STATUS;
            status.truncated = page_started;
            status.last = 1'b1;
            pending_results.push_back(status);
            restart_page();
            return;
         end
         case (phase)
            AWAIT_REPEAT: begin
               repeat_lines = b + 9'd1;
               column = '0;
               page_started = 1'b1;
               phase = AWAIT_CODE;
            end
            AWAIT_CODE: begin
               if (b == CODE_FILL) begin
                  place_run(eff_width(),
                            (bpp >= 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * bpp)) - 32'd1);
               end else begin
                  byte_count = '0;
                  pixel_accum = '0;
                  if (b <= 8'd127) begin
                     run_pixels = b + 8'd1;
                     phase = RUN_PIXEL;
                  end else begin
                     literal_left = 8'(257 - b);
                     phase = COPY_PIXEL;
                  end
               end
            end
            default: begin
               pixel_accum = {pixel_accum[23:0], b};
               byte_count++;
               if (byte_count < bpp) return;
               byte_count = '0;
               if (phase == RUN_PIXEL) begin
                  phase = AWAIT_CODE;
                  place_run(run_pixels, pixel_accum);
               end else begin
                  literal_left--;
                  phase = (literal_left == 0) ? AWAIT_CODE : COPY_PIXEL;
                  place_run(1, pixel_accum);
               end
               pixel_accum = '0;
            end
         endcase
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(input res_type got);
         res_type want;
         if (pending_results.size() == 0) begin
            $error("result_kind %0d arrived with nothing pending", got.kind);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("result_kind", want.kind, got.kind);
         compare_field("start_pos", want.start_pos, got.start_pos);
         compare_field("run_length", want.run_length, got.run_length);
         compare_field("pixel_value", want.pixel_value, got.pixel_value);
         compare_field("first_line", want.first_line, got.first_line);
         compare_field("line_count", want.line_count, got.line_count);
         compare_field("page_done", want.page_done, got.page_done);
         compare_field("truncated", want.truncated, got.truncated);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_write;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_kind;
   logic [7:0]              req_data_byte;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [1:0]              rsp_result_kind;
   logic [12:0]             rsp_start_pos;
   logic [COL_W-1:0]        rsp_run_length;
   logic [31:0]             rsp_pixel_value;
   logic [LINE_W-1:0]       rsp_first_line;
   logic [CNT_W-1:0]        rsp_line_count;
   logic                    rsp_page_done;
   logic                    rsp_truncated;
   logic                    rsp_last;

   raster_decode_scoreboard scoreboard = new();
   stream_item_type         byte_stream[$];
   bit                      req_calm;
   bit                      rsp_calm;

   raster_line_rle_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_run_length  (rsp_run_length),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_first_line  (rsp_first_line),
      .rsp_line_count  (rsp_line_count),
      .rsp_page_done   (rsp_page_done),
      .rsp_truncated   (rsp_truncated),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // result side: check each accepted result, then draw a stall for the next
   initial begin
      int hold;
      res_type got;
      hold = 0;
      rsp_calm = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.kind = result_kind_type'(rsp_result_kind);
            got.start_pos = rsp_start_pos;
            got.run_length = rsp_run_length;
            got.pixel_value = rsp_pixel_value;
            got.first_line = rsp_first_line;
            got.line_count = rsp_line_count;
            got.page_done = rsp_page_done;
            got.truncated = rsp_truncated;
            got.last = rsp_last;
            scoreboard.check_result(got);
            if ($urandom_range(0, 49) == 0) rsp_calm = !rsp_calm;
            hold = rsp_calm ? 0 : $urandom_range(0, 13);
         end
         rsp_stall <= (hold > 0);
         if (hold > 0) hold--;
      end
   end

   task automatic push_data(input logic [7:0] b);
      byte_stream.push_back({1'b0, b});
   endtask

   task automatic push_end();
      byte_stream.push_back({1'b1, 8'($urandom)});
   endtask

   task automatic send_stream();
      stream_item_type item;
      int gap;
      while (byte_stream.size() != 0) begin
         item = byte_stream.pop_front();
         if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
         gap = req_calm ? 0 : $urandom_range(0, 13);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_kind <= item.end_of_stream;
         req_data_byte <= item.data;
         do @(posedge clock); while (req_stall);
         scoreboard.note_item(item.end_of_stream, item.data);
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain_results(input int settle);
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // leaves csr_write high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      scoreboard.write_reg(idx, value);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width_word,
                            input logic [CSR_DATA_W-1:0] height_word,
                            input logic [CSR_DATA_W-1:0] bpp_word);
      write_csr(CSR_LINE_WIDTH, width_word);
      write_csr(CSR_PAGE_HEIGHT, height_word);
      write_csr(CSR_BYTES_PIXEL, bpp_word);
      csr_write <= 1'b0;
   endtask

   // one well-formed line for the current width and pixel size
   task automatic queue_line();
      int unsigned w, bpp, col, k;
      logic [7:0] code;
      w = scoreboard.eff_width();
      bpp = scoreboard.eff_bpp();
      col = 0;
      push_data(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 3)));
      while (col < w) begin
         case ($urandom_range(0, 9))
            0: begin
               push_data(CODE_FILL);
               col = w;
            end
            1, 2, 3, 4: begin
               code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 127))
                                                  : 8'($urandom_range(0, 7));
               push_data(code);
               repeat (bpp) push_data(8'($urandom));
               col += code + 1;
            end
            default: begin
               k = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 128)
                                               : $urandom_range(2, 8);
               push_data(8'(257 - k));
               // unused literals of a clipped run are not sent
               for (int i = 0; i < k && col < w; i++) begin
                  repeat (bpp) push_data(8'($urandom));
                  col++;
               end
            end
         endcase
      end
   endtask

   task automatic run_directed();
      logic [7:0] first_page[$];
      logic [7:0] wide_line[$];
      first_page = '{8'h01, 8'h02, 8'hAB, 8'hFE, 8'h11, 8'h22, 8'h33,
                     8'hFF, 8'h7F, 8'h00,
                     8'h00, 8'h81, 8'hFF, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08,
                     8'h03, 8'h01, 8'h5A, 8'h80,
                     8'h00, 8'h40};
      wide_line = '{8'hFF, 8'h80, 8'h00, 8'h7F, 8'hDE, 8'hAD, 8'hBE, 8'hEF};

      configure(16'd6, 16'd4, 16'd1);
      foreach (first_page[i]) push_data(first_page[i]);
      send_stream();
      // unused register index must leave the page in progress
      drain_results(4);
      write_csr(CSR_UNUSED, 16'hFFFF);
      csr_write <= 1'b0;
      push_end();
      push_end();
      send_stream();

      drain_results(4);
      configure(16'hFFFF, 16'hFFFF, 16'h0007);
      foreach (wide_line[i]) push_data(wide_line[i]);
      push_end();
      send_stream();

      drain_results(4);
      configure(16'h0000, 16'h0000, 16'h0000);
      push_data(8'h00);
      push_data(8'h00);
      push_data(8'h5A);
      push_end();
      send_stream();
   endtask

   initial begin
      int random_items, w, h, b;
      random_items = 0;
      req_calm = 1'b0;
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_kind <= 1'b0;
      req_data_byte <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      while (random_items < RANDOM_ITEMS) begin
         drain_results(4);
         case ($urandom_range(0, 5))
            0: w = 0;
            1: w = 1;
            default: w = $urandom_range(2, 24);
         endcase
         case ($urandom_range(0, 5))
            0: h = 0;
            1: h = 65535;
            default: h = $urandom_range(1, 6);
         endcase
         b = $urandom_range(0, 7);
         configure({2'($urandom), 14'(w)}, 16'(h), {13'($urandom), 3'(b)});
         while (byte_stream.size() < PHASE_ITEMS) begin
            case ($urandom_range(0, 19))
               0: push_end();
               1: repeat ($urandom_range(1, 3)) push_data(8'($urandom));
               2: begin
                  // line cut short by the end of the stream
                  repeat ($urandom_range(1, 5)) push_data(8'($urandom));
                  push_end();
               end
               default: queue_line();
            endcase
         end
         random_items += byte_stream.size();
         send_stream();
      end

      drain_results(8);
      if (scoreboard.errors == 0 && scoreboard.pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/rld_pkg.sv
rtl/raster_line_rle_decoder.sv
rtl/rld_checker.sv
dv/testbench.sv
